/* sv/scf_pkg.sv */
// Shared types and constants of the servo command packet framer.
// Used by the front, queue, back and top-level modules; depends on nothing.
`default_nettype none
package scf_pkg;

	typedef enum logic [1:0] {
		KIND_GOAL_WRITE   = 2'd0,
		KIND_ACTION       = 2'd1,
		KIND_TORQUE_WRITE = 2'd2,
		KIND_READ         = 2'd3
	} kind_t;

	localparam logic [7:0] HDR_BYTE     = 8'hFF;
	localparam logic [7:0] BCAST_ID     = 8'd254;
	localparam logic [7:0] INS_READ     = 8'd2;
	localparam logic [7:0] INS_WRITE    = 8'd3;
	localparam logic [7:0] INS_REGWRITE = 8'd4;
	localparam logic [7:0] INS_ACTION   = 8'd5;
	localparam logic [7:0] ADDR_TORQUE  = 8'h18;
	localparam logic [7:0] ADDR_GOAL    = 8'd24;
	localparam logic [7:0] ADDR_PRESENT = 8'd36;
	localparam logic [7:0] READ_COUNT   = 8'd6;
	localparam logic [7:0] GOAL_LEN     = 8'd15;
	localparam logic [7:0] LEN_ACTION   = 8'd2;
	localparam logic [7:0] LEN_SHORT    = 8'd4;

	// Body bytes sit between the two header bytes and the checksum.
	localparam int BODY_BYTES = 16;
	localparam int HDR_COUNT  = 2;

	// Index of the checksum byte per packet kind.
	localparam logic [4:0] LAST_GOAL   = 5'd18;
	localparam logic [4:0] LAST_ACTION = 5'd5;
	localparam logic [4:0] LAST_SHORT  = 5'd7;

	localparam logic [9:0] TORQUE_MAX = 10'd1023;

	typedef struct packed {
		logic [BODY_BYTES-1:0][7:0] body;
		logic [4:0]                 last_idx;
	} pkt_desc_t;

endpackage
`default_nettype wire

/* sv/scf_front.sv */
// Front stage: accepts a servo command, classifies it and builds the packet body.
// Depends on scf_pkg.
`default_nettype none
module scf_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [1:0]        kind,
	input  wire logic [7:0]        servo_id,
	input  wire logic [7:0]        torque_on,
	input  wire logic [7:0]        led_on,
	input  wire logic [7:0]        cw_margin,
	input  wire logic [7:0]        ccw_margin,
	input  wire logic [7:0]        cw_slope,
	input  wire logic [7:0]        ccw_slope,
	input  wire logic [9:0]        goal_position,
	input  wire logic [9:0]        moving_speed,
	input  wire logic [10:0]       torque_limit,
	output logic                   push,
	output scf_pkg::pkt_desc_t     push_desc,
	input  wire logic              q_full
);
	import scf_pkg::*;

	logic      valid_s1;
	pkt_desc_t desc_s1;
	pkt_desc_t desc_d;
	logic [9:0] tl_sat;
	logic      accept;

	assign in_stall  = valid_s1 && q_full;
	assign accept    = in_valid && !in_stall;
	assign push      = valid_s1 && !q_full;
	assign push_desc = desc_s1;

	// Saturate torque limit: anything above the 10-bit range goes out as the max.
	assign tl_sat = torque_limit[10] ? TORQUE_MAX : torque_limit[9:0];

	always_comb begin
		desc_d = '0;
		case (kind_t'(kind))
			KIND_GOAL_WRITE: begin
				desc_d.body[0]  = servo_id;
				desc_d.body[1]  = GOAL_LEN;
				desc_d.body[2]  = INS_REGWRITE;
				desc_d.body[3]  = ADDR_GOAL;
				desc_d.body[4]  = torque_on;
				desc_d.body[5]  = led_on;
				desc_d.body[6]  = cw_margin;
				desc_d.body[7]  = ccw_margin;
				desc_d.body[8]  = cw_slope;
				desc_d.body[9]  = ccw_slope;
				desc_d.body[10] = goal_position[7:0];
				desc_d.body[11] = {6'd0, goal_position[9:8]};
				desc_d.body[12] = moving_speed[7:0];
				desc_d.body[13] = {6'd0, moving_speed[9:8]};
				desc_d.body[14] = tl_sat[7:0];
				desc_d.body[15] = {6'd0, tl_sat[9:8]};
				desc_d.last_idx = LAST_GOAL;
			end
			KIND_ACTION: begin
				desc_d.body[0]  = BCAST_ID;
				desc_d.body[1]  = LEN_ACTION;
				desc_d.body[2]  = INS_ACTION;
				desc_d.last_idx = LAST_ACTION;
			end
			KIND_TORQUE_WRITE: begin
				desc_d.body[0]  = servo_id;
				desc_d.body[1]  = LEN_SHORT;
				desc_d.body[2]  = INS_WRITE;
				desc_d.body[3]  = ADDR_TORQUE;
				desc_d.body[4]  = torque_on;
				desc_d.last_idx = LAST_SHORT;
			end
			KIND_READ: begin
				desc_d.body[0]  = servo_id;
				desc_d.body[1]  = LEN_SHORT;
				desc_d.body[2]  = INS_READ;
				desc_d.body[3]  = ADDR_PRESENT;
				desc_d.body[4]  = READ_COUNT;
				desc_d.last_idx = LAST_SHORT;
			end
			default: begin
				desc_d.last_idx = LAST_SHORT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			desc_s1 <= desc_d;
		end
	end

endmodule
`default_nettype wire

/* sv/scf_queue.sv */
// Two-entry descriptor queue between the front and back stages.
// Depends on scf_pkg.
`default_nettype none
module scf_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire scf_pkg::pkt_desc_t push_desc,
	input  wire logic               pop,
	output logic                    full,
	output logic                    head_valid,
	output scf_pkg::pkt_desc_t      head_desc
);
	import scf_pkg::*;

	pkt_desc_t  entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_desc  = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3) else $error("queue count out of range");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!head_valid |-> !pop) else $error("pop from empty queue");

endmodule
`default_nettype wire

/* sv/scf_back.sv */
// Back stage: serializes the head descriptor into packet bytes with a running checksum.
// Depends on scf_pkg.
`default_nettype none
module scf_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               head_valid,
	input  wire scf_pkg::pkt_desc_t head_desc,
	output logic                    pop,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [7:0]              out_byte,
	output logic                    last_byte
);
	import scf_pkg::*;

	logic [4:0] idx_q;
	logic [7:0] sum_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       last_q;
	logic       advance;
	logic       load;
	logic       is_last;
	logic       is_hdr;
	logic [3:0] body_idx;
	logic [7:0] cur_byte;

	assign advance  = !out_valid_q || !out_stall;
	assign load     = advance && head_valid;
	assign is_last  = (idx_q == head_desc.last_idx);
	assign is_hdr   = (idx_q < 5'(HDR_COUNT));
	assign body_idx = 4'(idx_q - 5'(HDR_COUNT));
	assign pop      = load && is_last;

	always_comb begin
		if (is_hdr) begin
			cur_byte = HDR_BYTE;
		end else if (is_last) begin
			cur_byte = ~sum_q;
		end else begin
			cur_byte = head_desc.body[body_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 5'd0;
			sum_q       <= 8'd0;
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			if (is_last) begin
				idx_q <= 5'd0;
				sum_q <= 8'd0;
			end else begin
				idx_q <= idx_q + 5'd1;
				if (!is_hdr) begin
					sum_q <= sum_q + cur_byte;
				end
			end
		end else if (advance) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= cur_byte;
			last_q     <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last_byte = last_q;

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> idx_q <= head_desc.last_idx) else $error("byte index past packet end");
	a_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (idx_q == 5'd0 && sum_q == 8'd0)) else $error("packet end did not rewind");
	a_last_pop: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (last_byte == $past(pop))) else $error("last mark disagrees with pop");

endmodule
`default_nettype wire

/* sv/servo_command_packet_framer.sv */
// Servo command packet framer: one command in, one instruction packet out a byte at a time.
// Path: front register, then a queue entry, then the output byte register.
// Throughput: one byte per cycle when not stalled, set by the byte serializer; a packet
// has 19 bytes (goal write), 6 (action) or 8 (torque write, read request).
// Reset: arst_n clears all valid flags, queue pointers, byte index and checksum at once.
// Depends on scf_pkg, scf_front, scf_queue, scf_back.
`default_nettype none
module servo_command_packet_framer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  kind,
	input  wire logic [7:0]  servo_id,
	input  wire logic [7:0]  torque_on,
	input  wire logic [7:0]  led_on,
	input  wire logic [7:0]  cw_margin,
	input  wire logic [7:0]  ccw_margin,
	input  wire logic [7:0]  cw_slope,
	input  wire logic [7:0]  ccw_slope,
	input  wire logic [9:0]  goal_position,
	input  wire logic [9:0]  moving_speed,
	input  wire logic [10:0] torque_limit,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       out_byte,
	output logic             last_byte
);
	import scf_pkg::*;

	// Front to queue transfer.
	logic      push;
	pkt_desc_t push_desc;
	logic      q_full;

	// Queue head to back stage.
	logic      head_valid;
	pkt_desc_t head_desc;
	logic      pop;

	// Front: register the command and expand it into a packet body.
	// Hold the command while the queue is full.
	scf_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.servo_id     (servo_id),
		.torque_on    (torque_on),
		.led_on       (led_on),
		.cw_margin    (cw_margin),
		.ccw_margin   (ccw_margin),
		.cw_slope     (cw_slope),
		.ccw_slope    (ccw_slope),
		.goal_position(goal_position),
		.moving_speed (moving_speed),
		.torque_limit (torque_limit),
		.push         (push),
		.push_desc    (push_desc),
		.q_full       (q_full)
	);

	// Queue: two descriptors, so the front keeps taking commands while
	// the back is in the middle of a long packet.
	scf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.full      (q_full),
		.head_valid(head_valid),
		.head_desc (head_desc)
	);

	// Back: emit header, body and checksum; advance whenever the output
	// register is empty or its byte is being transferred, and drop the
	// descriptor on the checksum byte.
	scf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_desc (head_desc),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.last_byte (last_byte)
	);

endmodule
`default_nettype wire

/* sim/servo_packet_checker.sv */
// Checker for the servo command packet framer: watches both channels and compares every byte.
// Predicts each instruction packet from the accepted command; depends on scf_pkg only.
`default_nettype none
module servo_packet_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [1:0]  kind,
	input  wire logic [7:0]  servo_id,
	input  wire logic [7:0]  torque_on,
	input  wire logic [7:0]  led_on,
	input  wire logic [7:0]  cw_margin,
	input  wire logic [7:0]  ccw_margin,
	input  wire logic [7:0]  cw_slope,
	input  wire logic [7:0]  ccw_slope,
	input  wire logic [9:0]  goal_position,
	input  wire logic [9:0]  moving_speed,
	input  wire logic [10:0] torque_limit,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [7:0]  out_byte,
	input  wire logic        last_byte,
	input  wire logic        drain_done,
	output int               fail_count,
	output int               pending,
	output int               bytes_checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import scf_pkg::*;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} frame_byte_t;

	frame_byte_t frame_bytes_due[$];
	int          mismatches;
	int          bytes_seen;
	bit          drained;

	task automatic report_mismatch(input string what);
		if (mismatches < 50)
			$display("[%0t] MISMATCH: %s", $time, what);
		mismatches++;
	endtask

	// Build the whole instruction packet of one command and queue its bytes.
	task automatic frame_command();
		logic [7:0] pkt [0:18];
		logic [7:0] sum;
		logic [9:0] tl_sat;
		int         n;
		tl_sat = (torque_limit > {1'b0, TORQUE_MAX}) ? TORQUE_MAX : torque_limit[9:0];
		for (int i = 0; i < 19; i++)
			pkt[i] = 8'h00;
		pkt[0] = HDR_BYTE;
		pkt[1] = HDR_BYTE;
		case (kind_t'(kind))
			KIND_GOAL_WRITE: begin
				pkt[2]  = servo_id;
				pkt[3]  = GOAL_LEN;
				pkt[4]  = INS_REGWRITE;
				pkt[5]  = ADDR_GOAL;
				pkt[6]  = torque_on;
				pkt[7]  = led_on;
				pkt[8]  = cw_margin;
				pkt[9]  = ccw_margin;
				pkt[10] = cw_slope;
				pkt[11] = ccw_slope;
				pkt[12] = goal_position[7:0];
				pkt[13] = {6'd0, goal_position[9:8]};
				pkt[14] = moving_speed[7:0];
				pkt[15] = {6'd0, moving_speed[9:8]};
				pkt[16] = tl_sat[7:0];
				pkt[17] = {6'd0, tl_sat[9:8]};
				n = 19;
			end
			KIND_ACTION: begin
				pkt[2] = BCAST_ID;
				pkt[3] = LEN_ACTION;
				pkt[4] = INS_ACTION;
				n = 6;
			end
			KIND_TORQUE_WRITE: begin
				pkt[2] = servo_id;
				pkt[3] = LEN_SHORT;
				pkt[4] = INS_WRITE;
				pkt[5] = ADDR_TORQUE;
				pkt[6] = torque_on;
				n = 8;
			end
			default: begin
				pkt[2] = servo_id;
				pkt[3] = LEN_SHORT;
				pkt[4] = INS_READ;
				pkt[5] = ADDR_PRESENT;
				pkt[6] = READ_COUNT;
				n = 8;
			end
		endcase
		sum = 8'd0;
		for (int i = 2; i < n - 1; i++)
			sum = sum + pkt[i];
		pkt[n - 1] = ~sum;
		for (int i = 0; i < n; i++)
			frame_bytes_due.push_back('{data: pkt[i], last: (i == n - 1)});
	endtask

	always @(posedge clk or negedge arst_n) begin
		frame_byte_t due;
		if (!arst_n) begin
			frame_bytes_due.delete();
			mismatches    = 0;
			bytes_seen    = 0;
			drained       = 1'b0;
			fail_count    <= 0;
			pending       <= 0;
			bytes_checked <= 0;
		end else begin
			if (in_valid && !in_stall)
				frame_command();
			if (out_valid && !out_stall) begin
				if (frame_bytes_due.size() == 0) begin
					report_mismatch($sformatf("unexpected byte %02h last=%0b",
						out_byte, last_byte));
				end else begin
					due = frame_bytes_due.pop_front();
					if (out_byte !== due.data)
						report_mismatch($sformatf("out_byte %02h, expected %02h",
							out_byte, due.data));
					if (last_byte !== due.last)
						report_mismatch($sformatf("last_byte %0b, expected %0b on byte %02h",
							last_byte, due.last, due.data));
				end
				bytes_seen++;
			end
			if (drain_done && !drained) begin
				drained = 1'b1;
				if (frame_bytes_due.size() != 0)
					report_mismatch($sformatf("%0d packet bytes never arrived",
						frame_bytes_due.size()));
			end
			fail_count    <= mismatches;
			pending       <= frame_bytes_due.size();
			bytes_checked <= bytes_seen;
		end
	end

endmodule
`default_nettype wire

/* sim/tb_servo_command_packet_framer.sv */
// Testbench top for the servo command packet framer: drives commands, idles both channels.
// Depends on scf_pkg, servo_command_packet_framer and servo_packet_checker.
`default_nettype none
module tb_servo_command_packet_framer;
	timeunit 1ns;
	timeprecision 1ps;
	import scf_pkg::*;

	// Length of the one long output hold that backs the block up into its input.
	localparam int LONG_HOLD = 250;

	typedef struct packed {
		kind_t       k;
		logic [7:0]  id;
		logic [7:0]  torque;
		logic [7:0]  led;
		logic [7:0]  cw_m;
		logic [7:0]  ccw_m;
		logic [7:0]  cw_s;
		logic [7:0]  ccw_s;
		logic [9:0]  goal;
		logic [9:0]  speed;
		logic [10:0] tlimit;
	} servo_cmd_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  kind;
	logic [7:0]  servo_id;
	logic [7:0]  torque_on;
	logic [7:0]  led_on;
	logic [7:0]  cw_margin;
	logic [7:0]  ccw_margin;
	logic [7:0]  cw_slope;
	logic [7:0]  ccw_slope;
	logic [9:0]  goal_position;
	logic [9:0]  moving_speed;
	logic [10:0] torque_limit;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  out_byte;
	logic        last_byte;
	logic        drain_done;

	int fail_count;
	int pending;
	int bytes_checked;

	// Flags shared between the sender and receiver processes, and per-kind command counts.
	bit quiet;
	int hold_requests;
	int cmds_by_kind [4];

	servo_command_packet_framer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.servo_id     (servo_id),
		.torque_on    (torque_on),
		.led_on       (led_on),
		.cw_margin    (cw_margin),
		.ccw_margin   (ccw_margin),
		.cw_slope     (cw_slope),
		.ccw_slope    (ccw_slope),
		.goal_position(goal_position),
		.moving_speed (moving_speed),
		.torque_limit (torque_limit),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.last_byte    (last_byte)
	);

	servo_packet_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.kind         (kind),
		.servo_id     (servo_id),
		.torque_on    (torque_on),
		.led_on       (led_on),
		.cw_margin    (cw_margin),
		.ccw_margin   (ccw_margin),
		.cw_slope     (cw_slope),
		.ccw_slope    (ccw_slope),
		.goal_position(goal_position),
		.moving_speed (moving_speed),
		.torque_limit (torque_limit),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_byte     (out_byte),
		.last_byte    (last_byte),
		.drain_done   (drain_done),
		.fail_count   (fail_count),
		.pending      (pending),
		.bytes_checked(bytes_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog: the slowest legal run is well under a millisecond.
	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	// Byte fields lean on the extremes, otherwise uniform.
	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [9:0] pick_count();
		case ($urandom_range(0, 7))
			0:       return 10'd0;
			1:       return 10'd1023;
			default: return 10'($urandom_range(0, 1023));
		endcase
	endfunction

	// Torque limit: cover the full 11-bit code space and crowd the saturation edge.
	function automatic logic [10:0] pick_limit();
		case ($urandom_range(0, 7))
			0:       return 11'd0;
			1:       return 11'd2047;
			2, 3:    return 11'($urandom_range(1019, 1028));
			default: return 11'($urandom_range(0, 2047));
		endcase
	endfunction

	function automatic servo_cmd_t random_cmd();
		servo_cmd_t c;
		c.k      = kind_t'($urandom_range(0, 3));
		c.id     = pick_byte();
		c.torque = pick_byte();
		c.led    = pick_byte();
		c.cw_m   = pick_byte();
		c.ccw_m  = pick_byte();
		c.cw_s   = pick_byte();
		c.ccw_s  = pick_byte();
		c.goal   = pick_count();
		c.speed  = pick_count();
		c.tlimit = pick_limit();
		return c;
	endfunction

	// Directed commands: every byte field but the ID set to one fill value.
	function automatic servo_cmd_t plain_cmd(input kind_t k, input logic [7:0] id,
		input logic [7:0] fill, input logic [9:0] goal, input logic [9:0] speed,
		input logic [10:0] tlimit);
		servo_cmd_t c;
		c.k      = k;
		c.id     = id;
		c.torque = fill;
		c.led    = fill;
		c.cw_m   = fill;
		c.ccw_m  = fill;
		c.cw_s   = fill;
		c.ccw_s  = fill;
		c.goal   = goal;
		c.speed  = speed;
		c.tlimit = tlimit;
		return c;
	endfunction

	// Offer one command and hold it until the transfer; then maybe idle the input.
	task automatic offer(input servo_cmd_t c, input int gap_pct);
		kind          <= c.k;
		servo_id      <= c.id;
		torque_on     <= c.torque;
		led_on        <= c.led;
		cw_margin     <= c.cw_m;
		ccw_margin    <= c.ccw_m;
		cw_slope      <= c.cw_s;
		ccw_slope     <= c.ccw_s;
		goal_position <= c.goal;
		moving_speed  <= c.speed;
		torque_limit  <= c.tlimit;
		in_valid      <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		cmds_by_kind[c.k]++;
		if (!quiet && $urandom_range(1, 100) <= gap_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10))
				@(posedge clk);
		end
	endtask

	// Drop valid and wait until every queued packet byte has come out.
	task automatic drain_input();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Receiver: random stall bursts in moods that are redrawn every 30 to 90 stall decisions,
	// one long hold on request, and no stalls at all once the run goes quiet.
	initial begin : receiver
		int served;
		int calm;
		int mood;
		out_stall = 1'b0;
		served = 0;
		calm = 0;
		mood = 0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (served != hold_requests) begin
				out_stall <= 1'b1;
				repeat (LONG_HOLD)
					@(posedge clk);
				served++;
			end else if (quiet) begin
				out_stall <= 1'b0;
				@(posedge clk);
			end else begin
				if (calm == 0) begin
					mood = $urandom_range(0, 3);
					calm = $urandom_range(30, 90);
				end
				calm--;
				if (mood != 0 && $urandom_range(0, 7) < mood) begin
					out_stall <= 1'b1;
					repeat ($urandom_range(1, 10))
						@(posedge clk);
				end else begin
					out_stall <= 1'b0;
					@(posedge clk);
				end
			end
		end
	end

	// Sender: directed corners, random traffic, one pause, one backpressure phase,
	// then a quiet tail with no idling on either side.
	initial begin : sender
		int gap_pct;
		int waited;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		kind          = KIND_GOAL_WRITE;
		servo_id      = 8'h00;
		torque_on     = 8'h00;
		led_on        = 8'h00;
		cw_margin     = 8'h00;
		ccw_margin    = 8'h00;
		cw_slope      = 8'h00;
		ccw_slope     = 8'h00;
		goal_position = 10'd0;
		moving_speed  = 10'd0;
		torque_limit  = 11'd0;
		drain_done    = 1'b0;
		quiet         = 1'b0;
		hold_requests = 0;
		foreach (cmds_by_kind[i])
			cmds_by_kind[i] = 0;
		repeat (11)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Field extremes, every kind, torque saturation, ignored fields.
		offer(plain_cmd(KIND_GOAL_WRITE,   8'h00, 8'h00, 10'd0,     10'd0,     11'd0),    25);
		offer(plain_cmd(KIND_GOAL_WRITE,   8'hFF, 8'hFF, 10'd1023,  10'd1023,  11'd1023), 25);
		offer(plain_cmd(KIND_GOAL_WRITE,   8'h01, 8'h80, 10'd512,   10'd256,   11'd1024), 25);
		offer(plain_cmd(KIND_GOAL_WRITE,   8'hFE, 8'h7F, 10'd1,     10'd767,   11'd2047), 25);
		offer(plain_cmd(KIND_GOAL_WRITE,   8'h55, 8'h55, 10'h2AA,   10'h155,   11'd1025), 25);
		offer(plain_cmd(KIND_GOAL_WRITE,   8'hAA, 8'hAA, 10'h155,   10'h2AA,   11'd1022), 25);
		offer(plain_cmd(KIND_GOAL_WRITE,   BCAST_ID, 8'h01, 10'd255, 10'd256,  11'h555),  25);
		offer(plain_cmd(KIND_ACTION,       8'h00, 8'h00, 10'd0,     10'd0,     11'd0),    25);
		offer(plain_cmd(KIND_ACTION,       8'hFF, 8'hFF, 10'd1023,  10'd1023,  11'd2047), 25);
		offer(plain_cmd(KIND_ACTION,       BCAST_ID, 8'h5A, 10'd7,  10'd9,     11'd1024), 25);
		offer(plain_cmd(KIND_TORQUE_WRITE, 8'h00, 8'h00, 10'd0,     10'd0,     11'd0),    25);
		offer(plain_cmd(KIND_TORQUE_WRITE, 8'hFF, 8'hFF, 10'd1023,  10'd1023,  11'd2047), 25);
		offer(plain_cmd(KIND_TORQUE_WRITE, BCAST_ID, 8'h01, 10'd0,  10'd0,     11'd0),    25);
		offer(plain_cmd(KIND_READ,         8'h00, 8'h00, 10'd0,     10'd0,     11'd0),    25);
		offer(plain_cmd(KIND_READ,         8'hFF, 8'hFF, 10'd1023,  10'd1023,  11'd2047), 25);

		repeat (120)
			offer(random_cmd(), 25);

		// Pause the input until every outstanding byte has come out.
		drain_input();

		// Hold the output for a long stretch while offering back to back, so
		// the block fills up and stalls its input.
		hold_requests <= hold_requests + 1;
		repeat (30)
			offer(random_cmd(), 0);

		// Random traffic in stretches of differing input density.
		repeat (8) begin
			case ($urandom_range(0, 2))
				0:       gap_pct = 0;
				1:       gap_pct = 10;
				default: gap_pct = 40;
			endcase
			repeat (20)
				offer(random_cmd(), gap_pct);
		end

		// Tail with no idling on either side.
		quiet <= 1'b1;
		repeat (40)
			offer(random_cmd(), 0);

		// Wait out the remaining bytes, bounded, then wait on for strays before the drain check.
		in_valid <= 1'b0;
		@(posedge clk);
		waited = 0;
		while (pending != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8)
			@(posedge clk);
		drain_done <= 1'b1;
		repeat (2)
			@(posedge clk);

		$display("Covered %0d commands (goal write %0d, action %0d, torque write %0d, read %0d),",
			cmds_by_kind[0] + cmds_by_kind[1] + cmds_by_kind[2] + cmds_by_kind[3],
			cmds_by_kind[KIND_GOAL_WRITE], cmds_by_kind[KIND_ACTION],
			cmds_by_kind[KIND_TORQUE_WRITE], cmds_by_kind[KIND_READ]);
		$display("%0d packet bytes compared, with random stalls and a %0d-cycle output hold.",
			bytes_checked, LONG_HOLD);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire

/* files.f */
sv/scf_pkg.sv
sv/scf_front.sv
sv/scf_queue.sv
sv/scf_back.sv
sv/servo_command_packet_framer.sv
sim/servo_packet_checker.sv
sim/tb_servo_command_packet_framer.sv
